FILE: rtl/rbed_pkg.sv
package rbed_pkg;

    localparam int MOD_WIDTH_DEFAULT = 32;
    localparam int CFG_WIDTH         = 32;
    localparam int CFG_IDX_WIDTH     = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRIVATE_EXP = 2'd2;

    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET     = 32'd96091;
    localparam logic [CFG_WIDTH-1:0] PUBLIC_EXP_RESET  = 32'd5;
    localparam logic [CFG_WIDTH-1:0] PRIVATE_EXP_RESET = 32'd38189;

    localparam logic [7:0] PAD_BYTE    = 8'h20;
    localparam logic       REQ_ENCRYPT = 1'b0;
    localparam logic       REQ_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_WAIT,
        ST_CHECK,
        ST_RES_WAIT,
        ST_SQ_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_RES,
        MUL_SQUARE
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     write_base;
        logic     write_res;
        logic     exp_shift;
        logic     out_load;
    } rbed_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
    } rbed_status_t;

endpackage

FILE: rtl/rbed_modmul.sv
module rbed_modmul
    import rbed_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] op_a,
    input  logic [MOD_WIDTH-1:0] op_b,
    input  logic [MOD_WIDTH-1:0] modulus,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(MOD_WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] a_reg;
    logic [MOD_WIDTH-1:0] b_reg;

    logic [MOD_WIDTH+1:0] addend;
    logic [MOD_WIDTH+1:0] sum;
    logic [MOD_WIDTH+1:0] mod1;
    logic [MOD_WIDTH+1:0] mod2;
    logic [MOD_WIDTH-1:0] acc_next;

    // acc < m, so 2*acc + a stays below 3*m: one of three candidates is reduced
    always_comb
    begin
        addend = b_reg[MOD_WIDTH-1] ? {2'b00, a_reg} : '0;
        sum    = {1'b0, acc_reg, 1'b0} + addend;
        mod1   = {2'b00, modulus};
        mod2   = {1'b0, modulus, 1'b0};
        if (sum >= mod2)
        begin
            acc_next = MOD_WIDTH'(sum - mod2);
        end
        else if (sum >= mod1)
        begin
            acc_next = MOD_WIDTH'(sum - mod1);
        end
        else
        begin
            acc_next = MOD_WIDTH'(sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[MOD_WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/rbed_datapath.sv
module rbed_datapath
    import rbed_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbed_cmd_t            cmd,
    output rbed_status_t         status,
    input  logic                 req_type,
    input  logic [7:0]           first_byte,
    input  logic [7:0]           second_byte,
    input  logic                 second_present,
    input  logic [CFG_WIDTH-1:0] cipher_word,
    input  logic [((MOD_WIDTH < CFG_WIDTH) ? MOD_WIDTH : CFG_WIDTH)-1:0] modulus_cfg,
    input  logic [((MOD_WIDTH < CFG_WIDTH) ? MOD_WIDTH : CFG_WIDTH)-1:0] public_exp,
    input  logic [((MOD_WIDTH < CFG_WIDTH) ? MOD_WIDTH : CFG_WIDTH)-1:0] private_exp,
    output logic [MOD_WIDTH-1:0] res_value,
    output logic                 res_req,
    output logic                 res_last_in,
    input  logic                 last_item
);

    localparam int CFG_W = (MOD_WIDTH < CFG_WIDTH) ? MOD_WIDTH : CFG_WIDTH;

    logic [MOD_WIDTH-1:0] mod_reg;
    logic [CFG_W-1:0]     exp_reg;
    logic [MOD_WIDTH-1:0] base_reg;
    logic [MOD_WIDTH-1:0] res_reg;
    logic                 req_reg;
    logic                 last_reg;

    logic [15:0]          block;
    logic [MOD_WIDTH-1:0] mul_a;
    logic [MOD_WIDTH-1:0] mul_b;
    logic                 mul_done;
    logic [MOD_WIDTH-1:0] product;

    assign block = {first_byte, second_present ? second_byte : PAD_BYTE};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_REDUCE:
            begin
                mul_a = MOD_WIDTH'(1);
                mul_b = base_reg;
            end
            MUL_RES:
            begin
                mul_a = res_reg;
                mul_b = base_reg;
            end
            MUL_SQUARE:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
        endcase
    end

    rbed_modmul #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_reg),
        .done    (mul_done),
        .product (product)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mod_reg  <= MOD_WIDTH'(modulus_cfg);
            exp_reg  <= (req_type == REQ_DECRYPT) ? private_exp : public_exp;
            base_reg <= (req_type == REQ_DECRYPT) ? MOD_WIDTH'(cipher_word[CFG_W-1:0])
                                                  : MOD_WIDTH'(block);
            // 1 mod m, and zero when m is zero so that case needs no extra path
            res_reg  <= MOD_WIDTH'(modulus_cfg > CFG_W'(1));
            req_reg  <= req_type;
            last_reg <= last_item;
        end
        else
        begin
            if (cmd.write_base)
            begin
                base_reg <= product;
            end
            if (cmd.write_res)
            begin
                res_reg <= product;
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= {1'b0, exp_reg[CFG_W-1:1]};
            end
        end
    end

    assign status.mod_zero = (mod_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mul_done = mul_done;

    assign res_value   = res_reg;
    assign res_req     = req_reg;
    assign res_last_in = last_reg;

endmodule

FILE: rtl/rbed_ctrl.sv
module rbed_ctrl
    import rbed_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         out_free,
    input  rbed_status_t status,
    output logic         in_ready,
    output rbed_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RED_START;
                end
            end
            ST_RED_START:
            begin
                state_next = status.mod_zero ? ST_FINISH : ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    state_next = ST_RES_WAIT;
                end
                else
                begin
                    state_next = ST_SQ_WAIT;
                end
            end
            ST_RES_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.mul_start  = 1'b0;
        cmd.mul_sel    = MUL_SQUARE;
        cmd.write_base = 1'b0;
        cmd.write_res  = 1'b0;
        cmd.exp_shift  = 1'b0;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RED_START:
            begin
                cmd.mul_start = !status.mod_zero;
                cmd.mul_sel   = MUL_REDUCE;
            end
            ST_RED_WAIT:
            begin
                cmd.mul_sel    = MUL_REDUCE;
                cmd.write_base = status.mul_done;
            end
            ST_CHECK:
            begin
                cmd.mul_start = !status.exp_zero;
                cmd.mul_sel   = status.exp_lsb ? MUL_RES : MUL_SQUARE;
            end
            ST_RES_WAIT:
            begin
                // base is untouched by this product, so the square starts at once
                cmd.write_res = status.mul_done;
                cmd.mul_start = status.mul_done;
                cmd.mul_sel   = MUL_SQUARE;
            end
            ST_SQ_WAIT:
            begin
                cmd.write_base = status.mul_done;
                cmd.exp_shift  = status.mul_done;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rsa_block_encrypt_decrypt_unit.sv
// channel   direction  signals                               fields
// s_axis    in         tvalid tready tdata[55:0] tuser tlast  request block or cipher word
// m_axis    out        tvalid tready tdata[47:0] tlast        result value and bytes
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data register write
//
// one request at a time; a zero modulus skips the multiplier
// the modular multiplier is bit-serial and handles one multiplier bit per cycle
// the next request is taken while a finished result waits in the output register
// rst_n clears the control state and loads the default key registers
module rsa_block_encrypt_decrypt_unit
    import rbed_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // first_byte[7:0], second_byte[15:8], second_present[16], cipher_word[48:17]
    input  logic [55:0]              s_axis_tdata,
    // req_type[0]
    input  logic                     s_axis_tuser,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // result_value[31:0] (only [15:0] on decrypt), plain_high[39:32], plain_low[47:40]
    output logic [47:0]              m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data
);

    localparam int CFG_W = (MOD_WIDTH < CFG_WIDTH) ? MOD_WIDTH : CFG_WIDTH;

    logic [CFG_W-1:0] modulus_reg;
    logic [CFG_W-1:0] public_exp_reg;
    logic [CFG_W-1:0] private_exp_reg;

    rbed_cmd_t    cmd;
    rbed_status_t status;

    logic                 out_free;
    logic [MOD_WIDTH-1:0] res_value;
    logic                 res_req;
    logic                 res_last;
    logic [31:0]          res_low;
    logic [47:0]          out_word;

    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg;
    logic        out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= CFG_W'(MODULUS_RESET);
            public_exp_reg  <= CFG_W'(PUBLIC_EXP_RESET);
            private_exp_reg <= CFG_W'(PRIVATE_EXP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODULUS:     modulus_reg     <= cfg_data[CFG_W-1:0];
                CFG_PUBLIC_EXP:  public_exp_reg  <= cfg_data[CFG_W-1:0];
                CFG_PRIVATE_EXP: private_exp_reg <= cfg_data[CFG_W-1:0];
                default:         modulus_reg     <= modulus_reg;
            endcase
        end
    end

    rbed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    rbed_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_type       (s_axis_tuser),
        .first_byte     (s_axis_tdata[7:0]),
        .second_byte    (s_axis_tdata[15:8]),
        .second_present (s_axis_tdata[16]),
        .cipher_word    (s_axis_tdata[48:17]),
        .modulus_cfg    (modulus_reg),
        .public_exp     (public_exp_reg),
        .private_exp    (private_exp_reg),
        .res_value      (res_value),
        .res_req        (res_req),
        .res_last_in    (res_last),
        .last_item      (s_axis_tlast)
    );

    // result fits the modulus width, so the low CFG_W bits carry all of it below 32 bits
    assign res_low = 32'(res_value[CFG_W-1:0]);

    always_comb
    begin
        if (res_req == REQ_DECRYPT)
        begin
            out_word = {res_low[7:0], res_low[15:8], 16'h0000, res_low[15:0]};
        end
        else
        begin
            out_word = {16'h0000, res_low};
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_word;
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // one request at a time: an accepted request closes the input until it finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a request is in progress");

    // the multiplier has nothing running while the controller is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !status.mul_done)
        else $error("multiplier finished with no request in progress");

    // a result is written only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending output");

endmodule
